>>> hdl/ctmq_pkg.sv
package ctmq_pkg;

    localparam int unsigned ID_W    = 11;
    localparam int unsigned LEN_W   = 4;
    localparam int unsigned DATA_W  = 64;
    localparam int unsigned N_BYTES = 8;
    localparam logic [LEN_W-1:0] MAX_LEN = 4'd8;

    typedef enum logic [0:0] {
        OP_SEND       = 1'b0,
        OP_MBOX_EMPTY = 1'b1
    } op_t;

    typedef struct packed {
        logic [LEN_W-1:0]  length;
        logic              rtr;
        logic [ID_W-1:0]   id;
        logic [DATA_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } q_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic [DATA_W-1:0] keep_bytes(
        input logic [DATA_W-1:0] data,
        input logic [LEN_W-1:0]  len
    );
        logic [DATA_W-1:0] res;
        res = '0;
        for (int k = 0; k < N_BYTES; k++)
        begin
            if (LEN_W'(k) < len)
            begin
                res[k*8 +: 8] = data[k*8 +: 8];
            end
        end
        return res;
    endfunction

endpackage

>>> hdl/ctmq_queue.sv
module ctmq_queue #(
    parameter int unsigned QUEUE_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctmq_pkg::q_cmd_t    cmd,
    input  ctmq_pkg::entry_t    wdata,
    output ctmq_pkg::q_status_t status,
    output ctmq_pkg::entry_t    head
);

    localparam int unsigned PTR_W = $clog2(QUEUE_ENTRIES);

    ctmq_pkg::entry_t mem [QUEUE_ENTRIES];
    ctmq_pkg::entry_t head_reg;

    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_ENTRIES - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign status.empty = (rd_ptr_reg == wr_ptr_reg);
    assign status.full  = (next_slot(wr_ptr_reg) == rd_ptr_reg);
    assign head         = head_reg;

    assign rd_ptr_next = cmd.pop  ? next_slot(rd_ptr_reg) : rd_ptr_reg;
    assign wr_ptr_next = cmd.push ? next_slot(wr_ptr_reg) : wr_ptr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    // head is prefetched: always holds the entry at the read pointer
    always_ff @(posedge clk)
    begin
        if (cmd.push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= wdata;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.push && status.full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.pop && status.empty))
        else $error("pop from empty queue");

    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> !status.empty)
        else $error("queue empty after push");

endmodule

>>> hdl/ctmq_ctrl.sv
module ctmq_ctrl (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  opcode,
    input  logic                                  mailbox_free,
    input  logic [ctmq_pkg::ID_W-1:0]             msg_id,
    input  logic                                  msg_rtr,
    input  logic [ctmq_pkg::LEN_W-1:0]            msg_length,
    input  logic [ctmq_pkg::DATA_W-1:0]           msg_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  send_accepted,
    output logic                                  frame_valid,
    output logic [ctmq_pkg::ID_W-1:0]             frame_id,
    output logic                                  frame_rtr,
    output logic [ctmq_pkg::LEN_W-1:0]            frame_length,
    output logic [ctmq_pkg::DATA_W-1:0]           frame_data,
    output logic                                  draining,
    input  ctmq_pkg::q_status_t                   q_status,
    input  ctmq_pkg::entry_t                      q_head,
    output ctmq_pkg::q_cmd_t                      q_cmd,
    output ctmq_pkg::entry_t                      q_wdata
);

    // input stage
    logic                 in_valid_reg;
    ctmq_pkg::op_t        op_reg;
    logic                 mbox_reg;
    ctmq_pkg::entry_t     msg_reg;

    // state
    logic                 mode_reg;
    logic                 mode_next;

    // result stage
    logic                               out_valid_reg;
    logic                               accepted_reg;
    logic                               accepted_next;
    logic                               fvalid_reg;
    logic                               fvalid_next;
    logic [ctmq_pkg::ID_W-1:0]          fid_reg;
    logic [ctmq_pkg::ID_W-1:0]          fid_next;
    logic                               frtr_reg;
    logic                               frtr_next;
    logic [ctmq_pkg::LEN_W-1:0]         flen_reg;
    logic [ctmq_pkg::LEN_W-1:0]         flen_next;
    logic [ctmq_pkg::DATA_W-1:0]        fdata_reg;
    logic [ctmq_pkg::DATA_W-1:0]        fdata_next;

    logic advance;
    logic fire;
    logic [ctmq_pkg::LEN_W-1:0] len_sat;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign fire     = in_valid_reg && advance;

    assign len_sat = (msg_length > ctmq_pkg::MAX_LEN) ? ctmq_pkg::MAX_LEN : msg_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg         <= ctmq_pkg::op_t'(opcode);
            mbox_reg       <= mailbox_free;
            msg_reg.id     <= msg_id;
            msg_reg.rtr    <= msg_rtr;
            msg_reg.length <= len_sat;
            msg_reg.data   <= msg_data;
        end
        if (fire)
        begin
            accepted_reg <= accepted_next;
            fvalid_reg   <= fvalid_next;
            fid_reg      <= fid_next;
            frtr_reg     <= frtr_next;
            flen_reg     <= flen_next;
            fdata_reg    <= fdata_next;
        end
    end

    always_comb
    begin
        q_cmd         = '0;
        mode_next     = mode_reg;
        accepted_next = 1'b0;
        fvalid_next   = 1'b0;
        fid_next      = '0;
        frtr_next     = 1'b0;
        flen_next     = '0;
        fdata_next    = '0;
        case (op_reg)
            ctmq_pkg::OP_SEND:
            begin
                if (!mode_reg && mbox_reg)
                begin
                    accepted_next = 1'b1;
                    fvalid_next   = 1'b1;
                    fid_next      = msg_reg.id;
                    frtr_next     = msg_reg.rtr;
                    flen_next     = msg_reg.length;
                    fdata_next    = ctmq_pkg::keep_bytes(msg_reg.data, msg_reg.length);
                end
                else
                begin
                    q_cmd.push    = fire && !q_status.full;
                    accepted_next = !q_status.full;
                    mode_next     = 1'b1;
                end
            end
            ctmq_pkg::OP_MBOX_EMPTY:
            begin
                if (q_status.empty)
                begin
                    mode_next = 1'b0;
                end
                else
                begin
                    q_cmd.pop   = fire;
                    fvalid_next = 1'b1;
                    fid_next    = q_head.id;
                    frtr_next   = q_head.rtr;
                    flen_next   = q_head.length;
                    fdata_next  = ctmq_pkg::keep_bytes(q_head.data, q_head.length);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign q_wdata       = msg_reg;
    assign out_valid     = out_valid_reg;
    assign send_accepted = accepted_reg;
    assign frame_valid   = fvalid_reg;
    assign frame_id      = fid_reg;
    assign frame_rtr     = frtr_reg;
    assign frame_length  = flen_reg;
    assign frame_data    = fdata_reg;
    assign draining      = mode_reg;

    a_queue_implies_mode: assert property (@(posedge clk) disable iff (!rst_n)
        !q_status.empty |-> mode_reg)
        else $error("queued frames while not draining");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (flen_reg <= ctmq_pkg::MAX_LEN))
        else $error("frame length above eight");

    a_cmd_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (q_cmd.push || q_cmd.pop) |-> fire)
        else $error("queue command without a beat in flight");

endmodule

>>> hdl/can_tx_mailbox_overflow_queue_core.sv
// channel | handshake             | beat
// --------+-----------------------+----------------------------------------------
// in      | in_valid / in_ready   | opcode, mailbox_free, msg_id/rtr/length/data
// out     | out_valid / out_ready | send_accepted, frame_*, draining
//
// One beat per cycle in each direction while the output is not stalled; a result
// passes the input register, then the result register, and leaves on out_ready.
// The queue head is prefetched from the frame memory into a register, so a pop
// takes its frame from the head register rather than from the frame memory.
// Reset clears pointers, draining mode and valids; memory content is not cleared.
// A stalled output holds both stages; in_ready drops only when both are full
// and out_ready is low.
module can_tx_mailbox_overflow_queue_core #(
    parameter int unsigned QUEUE_ENTRIES = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        opcode,
    input  logic                        mailbox_free,
    input  logic [ctmq_pkg::ID_W-1:0]   msg_id,
    input  logic                        msg_rtr,
    input  logic [ctmq_pkg::LEN_W-1:0]  msg_length,
    input  logic [ctmq_pkg::DATA_W-1:0] msg_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        send_accepted,
    output logic                        frame_valid,
    output logic [ctmq_pkg::ID_W-1:0]   frame_id,
    output logic                        frame_rtr,
    output logic [ctmq_pkg::LEN_W-1:0]  frame_length,
    output logic [ctmq_pkg::DATA_W-1:0] frame_data,
    output logic                        draining
);

    ctmq_pkg::q_cmd_t    q_cmd;
    ctmq_pkg::q_status_t q_status;
    ctmq_pkg::entry_t    q_head;
    ctmq_pkg::entry_t    q_wdata;

    ctmq_queue #(
        .QUEUE_ENTRIES (QUEUE_ENTRIES)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (q_cmd),
        .wdata  (q_wdata),
        .status (q_status),
        .head   (q_head)
    );

    ctmq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .mailbox_free  (mailbox_free),
        .msg_id        (msg_id),
        .msg_rtr       (msg_rtr),
        .msg_length    (msg_length),
        .msg_data      (msg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .send_accepted (send_accepted),
        .frame_valid   (frame_valid),
        .frame_id      (frame_id),
        .frame_rtr     (frame_rtr),
        .frame_length  (frame_length),
        .frame_data    (frame_data),
        .draining      (draining),
        .q_status      (q_status),
        .q_head        (q_head),
        .q_cmd         (q_cmd),
        .q_wdata       (q_wdata)
    );

endmodule

>>> dv/can_tx_mailbox_overflow_queue_core_tb.sv
module can_tx_mailbox_overflow_queue_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned QDEPTH    = 16;
    localparam int unsigned ITEMS     = 500;
    localparam int unsigned CALM_FROM = 440;

    typedef struct packed {
        logic                        accepted;
        logic                        fv;
        logic [ctmq_pkg::ID_W-1:0]   id;
        logic                        rtr;
        logic [ctmq_pkg::LEN_W-1:0]  len;
        logic [ctmq_pkg::DATA_W-1:0] data;
        logic                        drain;
    } handoff_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        opcode;
    logic                        mailbox_free;
    logic [ctmq_pkg::ID_W-1:0]   msg_id;
    logic                        msg_rtr;
    logic [ctmq_pkg::LEN_W-1:0]  msg_length;
    logic [ctmq_pkg::DATA_W-1:0] msg_data;
    logic                        out_valid;
    logic                        out_ready;
    logic                        send_accepted;
    logic                        frame_valid;
    logic [ctmq_pkg::ID_W-1:0]   frame_id;
    logic                        frame_rtr;
    logic [ctmq_pkg::LEN_W-1:0]  frame_length;
    logic [ctmq_pkg::DATA_W-1:0] frame_data;
    logic                        draining;

    // shadow of the transmit ring and draining mode
    ctmq_pkg::entry_t tx_ring [QDEPTH];
    int unsigned      rd_idx     = 0;
    int unsigned      wr_idx     = 0;
    bit               drain_mode = 1'b0;

    handoff_t    pending_handoffs[$];
    int unsigned beats_sent = 0;
    int unsigned mismatches = 0;
    bit          quiet      = 1'b0;

    can_tx_mailbox_overflow_queue_core #(
        .QUEUE_ENTRIES (QDEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .mailbox_free  (mailbox_free),
        .msg_id        (msg_id),
        .msg_rtr       (msg_rtr),
        .msg_length    (msg_length),
        .msg_data      (msg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .send_accepted (send_accepted),
        .frame_valid   (frame_valid),
        .frame_id      (frame_id),
        .frame_rtr     (frame_rtr),
        .frame_length  (frame_length),
        .frame_data    (frame_data),
        .draining      (draining)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("can_tx_mailbox_overflow_queue_core_tb: FAIL");
        $finish;
    end

    function automatic handoff_t mailbox_frame(ctmq_pkg::entry_t e);
        handoff_t h;
        logic [ctmq_pkg::DATA_W-1:0] mask;
        h = '0;
        if (e.length >= ctmq_pkg::MAX_LEN)
            mask = {ctmq_pkg::DATA_W{1'b1}};
        else
            mask = (ctmq_pkg::DATA_W'(1) << (e.length * 8)) - ctmq_pkg::DATA_W'(1);
        h.fv   = 1'b1;
        h.id   = e.id;
        h.rtr  = e.rtr;
        h.len  = e.length;
        h.data = e.data & mask;
        return h;
    endfunction

    function automatic handoff_t predict_handoff(ctmq_pkg::op_t op, logic mbox,
                                                 logic [ctmq_pkg::ID_W-1:0] id,
                                                 logic rtr,
                                                 logic [ctmq_pkg::LEN_W-1:0] len,
                                                 logic [ctmq_pkg::DATA_W-1:0] data);
        handoff_t         h;
        ctmq_pkg::entry_t e;
        int unsigned      fill;
        h        = '0;
        e.length = (len > ctmq_pkg::MAX_LEN) ? ctmq_pkg::MAX_LEN : len;
        e.rtr    = rtr;
        e.id     = id;
        e.data   = data;
        if (op == ctmq_pkg::OP_SEND)
        begin
            if (!drain_mode && mbox)
            begin
                h = mailbox_frame(e);
                h.accepted = 1'b1;
            end
            else
            begin
                fill = (wr_idx + QDEPTH - rd_idx) % QDEPTH;
                if (fill < QDEPTH - 1)
                begin
                    tx_ring[wr_idx] = e;
                    wr_idx = (wr_idx + 1) % QDEPTH;
                    h.accepted = 1'b1;
                end
                drain_mode = 1'b1;
            end
        end
        else if (rd_idx == wr_idx)
        begin
            drain_mode = 1'b0;
        end
        else
        begin
            h = mailbox_frame(tx_ring[rd_idx]);
            rd_idx = (rd_idx + 1) % QDEPTH;
        end
        h.drain = drain_mode;
        return h;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [ctmq_pkg::DATA_W-1:0] got,
                               logic [ctmq_pkg::DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    always @(posedge clk)
    begin
        handoff_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_handoffs.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
            end
            else
            begin
                want = pending_handoffs.pop_front();
                check_field("send_accepted", ctmq_pkg::DATA_W'(send_accepted),
                            ctmq_pkg::DATA_W'(want.accepted));
                check_field("frame_valid", ctmq_pkg::DATA_W'(frame_valid),
                            ctmq_pkg::DATA_W'(want.fv));
                check_field("frame_id", ctmq_pkg::DATA_W'(frame_id),
                            ctmq_pkg::DATA_W'(want.id));
                check_field("frame_rtr", ctmq_pkg::DATA_W'(frame_rtr),
                            ctmq_pkg::DATA_W'(want.rtr));
                check_field("frame_length", ctmq_pkg::DATA_W'(frame_length),
                            ctmq_pkg::DATA_W'(want.len));
                check_field("frame_data", frame_data, want.data);
                check_field("draining", ctmq_pkg::DATA_W'(draining),
                            ctmq_pkg::DATA_W'(want.drain));
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic send_beat(ctmq_pkg::op_t op, logic mbox,
                             logic [ctmq_pkg::ID_W-1:0] id, logic rtr,
                             logic [ctmq_pkg::LEN_W-1:0] len,
                             logic [ctmq_pkg::DATA_W-1:0] data);
        opcode       <= op;
        mailbox_free <= mbox;
        msg_id       <= id;
        msg_rtr      <= rtr;
        msg_length   <= len;
        msg_data     <= data;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_handoffs.push_back(predict_handoff(op, mbox, id, rtr, len, data));
        beats_sent++;
        idle_gap();
    endtask

    task automatic send_random(ctmq_pkg::op_t op, logic mbox);
        logic [ctmq_pkg::LEN_W-1:0]  len;
        logic [ctmq_pkg::DATA_W-1:0] data;
        if ($urandom_range(0, 6) == 0)
            len = ctmq_pkg::LEN_W'($urandom_range(9, 15));
        else
            len = ctmq_pkg::LEN_W'($urandom_range(0, 8));
        case ($urandom_range(0, 9))
            0:       data = '0;
            1:       data = '1;
            default: data = {$urandom, $urandom};
        endcase
        send_beat(op, mbox, ctmq_pkg::ID_W'($urandom_range(0, 2047)),
                  1'($urandom_range(0, 1)), len, data);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_handoffs.size() != 0);
    endtask

    task automatic test_bypass_extremes();
        send_beat(ctmq_pkg::OP_SEND, 1'b1, 11'd0,    1'b0, 4'd0,  '1);
        send_beat(ctmq_pkg::OP_SEND, 1'b1, 11'h7FF,  1'b1, 4'd8,  '1);
        send_beat(ctmq_pkg::OP_SEND, 1'b1, 11'h2AA,  1'b0, 4'd15, 64'hA5A5_5A5A_0123_4567);
        send_beat(ctmq_pkg::OP_SEND, 1'b1, 11'h555,  1'b1, 4'd9,  '1);
        send_beat(ctmq_pkg::OP_SEND, 1'b1, 11'h123,  1'b0, 4'd3,  '1);
        send_beat(ctmq_pkg::OP_SEND, 1'b1, 11'h400,  1'b1, 4'd1,  {$urandom, $urandom});
        send_beat(ctmq_pkg::OP_SEND, 1'b1, 11'h001,  1'b0, 4'd8,  '0);
    endtask

    task automatic test_event_while_idle();
        send_beat(ctmq_pkg::OP_MBOX_EMPTY, 1'b0, 11'h0F0, 1'b0, 4'd4,  {$urandom, $urandom});
        send_beat(ctmq_pkg::OP_MBOX_EMPTY, 1'b1, 11'h7FF, 1'b1, 4'd15, '1);
    endtask

    task automatic test_queue_and_drain();
        send_beat(ctmq_pkg::OP_SEND, 1'b0, 11'h7FF, 1'b1, 4'd5,  '1);
        send_beat(ctmq_pkg::OP_SEND, 1'b1, 11'h000, 1'b0, 4'd8,  {$urandom, $urandom});
        send_beat(ctmq_pkg::OP_SEND, 1'b0, 11'h3C3, 1'b0, 4'd12, '1);
        send_beat(ctmq_pkg::OP_SEND, 1'b1, 11'h111, 1'b1, 4'd0,  '1);
        repeat (4) send_random(ctmq_pkg::OP_MBOX_EMPTY, 1'b0);
        send_random(ctmq_pkg::OP_MBOX_EMPTY, 1'b1);
        send_random(ctmq_pkg::OP_MBOX_EMPTY, 1'b0);
        send_beat(ctmq_pkg::OP_SEND, 1'b1, 11'h246, 1'b0, 4'd7,  '1);
    endtask

    task automatic test_random_traffic();
        int unsigned n;
        int unsigned m;
        while (beats_sent < ITEMS)
        begin
            if (beats_sent >= CALM_FROM)
                quiet = 1'b1;
            if ($urandom_range(0, 4) != 0)
            begin
                n = $urandom_range(1, 20);
                repeat (n) send_random(ctmq_pkg::OP_SEND, 1'($urandom_range(0, 3) != 0));
                m = $urandom_range(1, n + 2);
                repeat (m) send_random(ctmq_pkg::OP_MBOX_EMPTY, 1'($urandom_range(0, 1)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_random(ctmq_pkg::op_t'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1)));
            end
            if (!quiet && $urandom_range(0, 14) == 0)
                wait_for_drain();
        end
    endtask

    initial
    begin
        int unsigned guard;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = 1'b0;
        mailbox_free = 1'b0;
        msg_id       = '0;
        msg_rtr      = 1'b0;
        msg_length   = '0;
        msg_data     = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_bypass_extremes();
        test_event_while_idle();
        test_queue_and_drain();
        wait_for_drain();
        test_random_traffic();

        in_valid <= 1'b0;
        guard = 0;
        while (pending_handoffs.size() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (10) @(posedge clk);
        if (pending_handoffs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_handoffs.size()));

        if (mismatches == 0)
            $display("can_tx_mailbox_overflow_queue_core_tb: PASS");
        else
            $display("can_tx_mailbox_overflow_queue_core_tb: FAIL");
        $finish;
    end

endmodule
